// ===== hdl/wifi_mac_header_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// wifi mac header parser unit - assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, held off in reset
// ----------------------------------------------------------------------------
`ifndef WIFI_MAC_HEADER_PARSER_UNIT_MACROS_SVH
`define WIFI_MAC_HEADER_PARSER_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define WMHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define WMHP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/wmhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wmhp_pkg
// types, constants and header length helpers for the 802.11 header parser
// ----------------------------------------------------------------------------
package wmhp_pkg;

  localparam int MAX_FRAME_BYTES = 8191;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int BYTE_W          = 8;
  localparam int ADDR_W          = 48;
  localparam int HDR_LEN_W       = 6;
  localparam int FC_W            = 16;

  // frame byte positions
  localparam int FC_LOW_POS      = 0;
  localparam int FC_HIGH_POS     = 1;
  localparam int ADDR1_POS       = 4;
  localparam int ADDR2_POS       = 10;
  localparam int ADDR3_POS       = 16;
  localparam int ADDR_END_POS    = 22;
  localparam int FIXED_FIELDS_LEN = 12;
  localparam int MIN_FRAME_LEN   = 2;

  // header lengths
  localparam int HDR_LEN_MGMT     = 24;
  localparam int HDR_LEN_DATA3    = 24;
  localparam int HDR_LEN_DATA4    = 30;
  localparam int HDR_LEN_QOS_EXTRA = 2;
  localparam int HDR_LEN_CTRL_ACK = 10;
  localparam int HDR_LEN_CTRL_RTS = 16;
  localparam int HDR_LEN_MIN      = 4;

  // subtypes and tags
  localparam logic [3:0] SUBTYPE_BEACON     = 4'd8;
  localparam logic [3:0] SUBTYPE_PROBE_RESP = 4'd5;
  localparam logic [3:0] SUBTYPE_CTS        = 4'd12;
  localparam logic [3:0] SUBTYPE_ACK        = 4'd13;
  localparam logic [BYTE_W-1:0] TAG_ID_SSID   = 8'd0;
  localparam logic [BYTE_W-1:0] TAG_ID_RSN    = 8'd48;
  localparam logic [BYTE_W-1:0] RSN_BODY_LEN  = 8'd20;
  localparam logic [BYTE_W-1:0] RSN_AKM_INDEX = 8'd17;

  localparam logic [ADDR_W-1:0] ADDR_NONE = {ADDR_W{1'b1}};

  // result packing
  localparam int OUT_FIELDS_W = 3 + HDR_LEN_W + 1 + 3 * ADDR_W + 1 + 1 + BYTE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_CONTROL   = 3'd2,
    ST_FOUR_ADDR = 3'd3,
    ST_RESERVED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_MGMT = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_DATA = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TAG_ID   = 2'd0,
    TAG_LEN  = 2'd1,
    TAG_BODY = 2'd2
  } tag_phase_e;

  localparam logic [1:0] DS_NONE = 2'b00;
  localparam logic [1:0] DS_FROM = 2'b10;
  localparam logic [1:0] DS_BOTH = 2'b11;

  // everything the result needs once the last byte is in
  typedef struct packed {
    logic [FC_W-1:0]   fc;
    logic              pad;
    logic [CNT_W-1:0]  len;
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W-1:0] a2;
    logic [ADDR_W-1:0] a3;
    logic              ssid;
    logic              rsn;
    logic [BYTE_W-1:0] akm;
  } frame_info_t;

  typedef struct packed {
    status_e              status;
    kind_e                kind;
    logic [HDR_LEN_W-1:0] hdr_len;
    logic                 prot;
    logic [ADDR_W-1:0]    sta;
    logic [ADDR_W-1:0]    ap;
    logic [ADDR_W-1:0]    bss;
    logic                 ssid;
    logic                 rsn;
    logic [BYTE_W-1:0]    akm;
  } result_t;

  function automatic logic [HDR_LEN_W-1:0] header_len(input logic [FC_W-1:0] fc,
                                                      input logic pad);
    logic [3:0]           sub;
    logic [HDR_LEN_W-1:0] len;
    logic [HDR_LEN_W-1:0] rounded;
    sub = fc[7:4];
    unique case (kind_e'(fc[3:2]))
      KIND_MGMT: len = HDR_LEN_W'(HDR_LEN_MGMT);
      KIND_CTRL: begin
        if (sub == SUBTYPE_CTS || sub == SUBTYPE_ACK) begin
          len = HDR_LEN_W'(HDR_LEN_CTRL_ACK);
        end else if (sub[3]) begin
          len = HDR_LEN_W'(HDR_LEN_CTRL_RTS);
        end else begin
          len = HDR_LEN_W'(HDR_LEN_MIN);
        end
      end
      KIND_DATA: begin
        len = (fc[9:8] == DS_BOTH) ? HDR_LEN_W'(HDR_LEN_DATA4) : HDR_LEN_W'(HDR_LEN_DATA3);
        if (sub[3]) begin
          len = len + HDR_LEN_W'(HDR_LEN_QOS_EXTRA);
        end
      end
      default: len = HDR_LEN_W'(HDR_LEN_MIN);
    endcase
    rounded = (len + HDR_LEN_W'(3)) & ~HDR_LEN_W'(3);
    return pad ? rounded : len;
  endfunction

  // beacons and probe responses carry tagged parameters
  function automatic logic tags_active(input logic [FC_W-1:0] fc);
    return (fc[3:2] == KIND_MGMT) &&
           (fc[7:4] == SUBTYPE_BEACON || fc[7:4] == SUBTYPE_PROBE_RESP);
  endfunction

endpackage

// ===== hdl/wmhp_result_calc.sv =====
// ----------------------------------------------------------------------------
// wmhp_result_calc
// builds the frame summary from the captured frame state
// ----------------------------------------------------------------------------
module wmhp_result_calc (
  input  wmhp_pkg::frame_info_t info_i,
  output wmhp_pkg::result_t     res_o
);
  import wmhp_pkg::*;

  logic [HDR_LEN_W-1:0] hl;
  kind_e                kind;
  status_e              status;
  logic [1:0]           ds;

  assign hl   = header_len(info_i.fc, info_i.pad);
  assign kind = kind_e'(info_i.fc[3:2]);
  assign ds   = info_i.fc[9:8];

  // length check comes before the frame type
  always_comb begin
    priority if (info_i.len < CNT_W'(MIN_FRAME_LEN) || info_i.len < CNT_W'(hl)) begin
      status = ST_SHORT;
    end else if (kind == KIND_CTRL) begin
      status = ST_CONTROL;
    end else if (kind == KIND_RSVD) begin
      status = ST_RESERVED;
    end else if (kind == KIND_DATA && ds == DS_BOTH) begin
      status = ST_FOUR_ADDR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_o         = '0;
    res_o.status  = status;
    res_o.kind    = kind;
    res_o.prot    = info_i.fc[14];
    if (status == ST_OK) begin
      res_o.hdr_len = hl;
      if (kind == KIND_MGMT) begin
        res_o.ap = info_i.a3;
        priority if (info_i.a1 != info_i.a3) begin
          res_o.sta = info_i.a1;
        end else if (info_i.a2 != info_i.a3) begin
          res_o.sta = info_i.a2;
        end else begin
          res_o.sta = ADDR_NONE;
        end
        if (tags_active(info_i.fc)) begin
          res_o.ssid = info_i.ssid;
          res_o.rsn  = info_i.rsn;
          res_o.akm  = info_i.akm;
        end
      end else begin
        unique case (ds)
          DS_NONE: begin
            res_o.ap  = info_i.a3;
            res_o.bss = info_i.a3;
            res_o.sta = ADDR_NONE;
          end
          DS_FROM: begin
            res_o.sta = info_i.a1;
            res_o.ap  = info_i.a2;
            res_o.bss = info_i.a2;
          end
          default: begin
            res_o.ap  = info_i.a1;
            res_o.bss = info_i.a1;
            res_o.sta = info_i.a2;
          end
        endcase
      end
    end
  end

endmodule

// ===== hdl/wifi_mac_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// wifi_mac_header_parser_unit
// 802.11 mac header parser: one frame byte per transaction, one summary per frame
// ----------------------------------------------------------------------------
// Frame bytes stream in on the slave side, starting at the frame control field,
// one byte per transaction; tlast marks the final captured byte and tuser, taken
// with the first byte, asks for the header length to be rounded up to a multiple
// of four. The unit accepts one byte every cycle with no gaps between frames
// unless a last byte is held back by an unread summary. Each byte is first held
// in an input register and in the next cycle updates the frame state (frame
// control, three addresses, byte count, tag walk over beacon and probe response
// bodies); on the last byte the summary is formed from that updated state in the
// same cycle and loaded into the output register, so a summary is offered only
// after its last byte has passed through the input register and the output
// register. The per-frame state is cleared as the last byte leaves the input
// register, so the next frame may follow at once. Bytes beyond the maximum frame
// length are ignored except for tlast. While a summary waits on the master side,
// bytes are still taken until a further last byte reaches the input register.
`include "wifi_mac_header_parser_unit_macros.svh"

module wifi_mac_header_parser_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave side: frame bytes
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [wmhp_pkg::BYTE_W-1:0]          s_axis_tdata_i,   // data_byte
  input  logic                                 s_axis_tlast_i,   // last_byte
  input  logic                                 s_axis_tuser_i,   // pad_to_four
  // master side: frame summary
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // status[2:0], header_length[8:3], protected_flag[9], station_address[57:10],
  // ap_address[105:58], bssid_address[153:106], ssid_present[154],
  // rsn_found[155], rsn_akm[163:156], zero fill above
  output logic [wmhp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic [wmhp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser_o    // frame_kind
);
  import wmhp_pkg::*;

  // input register
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              in_pad_q;

  logic s_acc;
  logic advance;   // input register content is consumed this cycle

  // frame state
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_upd;
  logic [FC_W-1:0]   fc_q, fc_d, fc_upd;
  logic              pad_q, pad_d, pad_upd;
  logic [ADDR_W-1:0] a1_q, a1_d, a1_upd;
  logic [ADDR_W-1:0] a2_q, a2_d, a2_upd;
  logic [ADDR_W-1:0] a3_q, a3_d, a3_upd;

  // tag walk state
  tag_phase_e        phase_q, phase_d, phase_upd;
  logic [BYTE_W-1:0] tag_id_q, tag_id_d, tag_id_upd;
  logic [BYTE_W-1:0] rem_q, rem_d, rem_upd;
  logic [BYTE_W-1:0] bidx_q, bidx_d, bidx_upd;
  logic              pssid_q, pssid_d, pssid_upd;   // first name byte nonzero
  logic [BYTE_W-1:0] pakm_q, pakm_d, pakm_upd;      // candidate akm byte
  logic              ssid_q, ssid_d, ssid_upd;
  logic              rsn_q, rsn_d, rsn_upd;
  logic [BYTE_W-1:0] akm_q, akm_d, akm_upd;

  logic [CNT_W-1:0]  tag_start;
  frame_info_t       info;
  result_t           res;

  // output register
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // ---------------------------------------------------------------- handshake
  // a held last byte waits only while a previous summary is still unread
  assign advance         = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
      in_pad_q  <= s_axis_tuser_i;
    end
  end

  // ---------------------------------------------------------------- byte update
  // tagged parameters start after the header and the fixed management fields
  assign tag_start = CNT_W'(header_len(fc_q, pad_q)) + CNT_W'(FIXED_FIELDS_LEN);

  always_comb begin
    cnt_upd    = cnt_q;
    fc_upd     = fc_q;
    pad_upd    = pad_q;
    a1_upd     = a1_q;
    a2_upd     = a2_q;
    a3_upd     = a3_q;
    phase_upd  = phase_q;
    tag_id_upd = tag_id_q;
    rem_upd    = rem_q;
    bidx_upd   = bidx_q;
    pssid_upd  = pssid_q;
    pakm_upd   = pakm_q;
    ssid_upd   = ssid_q;
    rsn_upd    = rsn_q;
    akm_upd    = akm_q;

    if (cnt_q < CNT_W'(MAX_FRAME_BYTES)) begin
      cnt_upd = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(FC_LOW_POS)) begin
        pad_upd = in_pad_q;
        fc_upd  = {{(FC_W-BYTE_W){1'b0}}, in_byte_q};
      end else if (cnt_q == CNT_W'(FC_HIGH_POS)) begin
        fc_upd = {in_byte_q, fc_q[BYTE_W-1:0]};
      end else if (cnt_q >= CNT_W'(ADDR1_POS) && cnt_q < CNT_W'(ADDR2_POS)) begin
        a1_upd = {a1_q[ADDR_W-BYTE_W-1:0], in_byte_q};
      end else if (cnt_q >= CNT_W'(ADDR2_POS) && cnt_q < CNT_W'(ADDR3_POS)) begin
        a2_upd = {a2_q[ADDR_W-BYTE_W-1:0], in_byte_q};
      end else if (cnt_q >= CNT_W'(ADDR3_POS) && cnt_q < CNT_W'(ADDR_END_POS)) begin
        a3_upd = {a3_q[ADDR_W-BYTE_W-1:0], in_byte_q};
      end else if (tags_active(fc_q) && cnt_q >= tag_start) begin
        // walk: tag id, length, then body bytes
        unique case (phase_q)
          TAG_ID: begin
            tag_id_upd = in_byte_q;
            phase_upd  = TAG_LEN;
          end
          TAG_LEN: begin
            rem_upd   = in_byte_q;
            bidx_upd  = '0;
            pssid_upd = 1'b0;
            pakm_upd  = '0;
            phase_upd = (in_byte_q == '0) ? TAG_ID : TAG_BODY;
          end
          default: begin
            if (bidx_q == '0 && in_byte_q != '0) begin
              pssid_upd = 1'b1;
            end
            if (bidx_q == RSN_AKM_INDEX) begin
              pakm_upd = in_byte_q;
            end
            bidx_upd = bidx_q + BYTE_W'(1);
            rem_upd  = rem_q - BYTE_W'(1);
            if (rem_q == BYTE_W'(1)) begin
              if (tag_id_q == TAG_ID_SSID && pssid_upd) begin
                ssid_upd = 1'b1;
              end
              if (tag_id_q == TAG_ID_RSN && bidx_upd == RSN_BODY_LEN) begin
                rsn_upd = 1'b1;
                akm_upd = pakm_upd;
              end
              phase_upd = TAG_ID;
            end
          end
        endcase
      end
    end
  end

  // state after this byte; cleared once the frame's last byte is consumed
  always_comb begin
    cnt_d    = cnt_q;
    fc_d     = fc_q;
    pad_d    = pad_q;
    a1_d     = a1_q;
    a2_d     = a2_q;
    a3_d     = a3_q;
    phase_d  = phase_q;
    tag_id_d = tag_id_q;
    rem_d    = rem_q;
    bidx_d   = bidx_q;
    pssid_d  = pssid_q;
    pakm_d   = pakm_q;
    ssid_d   = ssid_q;
    rsn_d    = rsn_q;
    akm_d    = akm_q;
    if (advance) begin
      if (in_last_q) begin
        cnt_d    = '0;
        fc_d     = '0;
        pad_d    = 1'b0;
        a1_d     = '0;
        a2_d     = '0;
        a3_d     = '0;
        phase_d  = TAG_ID;
        tag_id_d = '0;
        rem_d    = '0;
        bidx_d   = '0;
        pssid_d  = 1'b0;
        pakm_d   = '0;
        ssid_d   = 1'b0;
        rsn_d    = 1'b0;
        akm_d    = '0;
      end else begin
        cnt_d    = cnt_upd;
        fc_d     = fc_upd;
        pad_d    = pad_upd;
        a1_d     = a1_upd;
        a2_d     = a2_upd;
        a3_d     = a3_upd;
        phase_d  = phase_upd;
        tag_id_d = tag_id_upd;
        rem_d    = rem_upd;
        bidx_d   = bidx_upd;
        pssid_d  = pssid_upd;
        pakm_d   = pakm_upd;
        ssid_d   = ssid_upd;
        rsn_d    = rsn_upd;
        akm_d    = akm_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      fc_q     <= '0;
      pad_q    <= 1'b0;
      a1_q     <= '0;
      a2_q     <= '0;
      a3_q     <= '0;
      phase_q  <= TAG_ID;
      tag_id_q <= '0;
      rem_q    <= '0;
      bidx_q   <= '0;
      pssid_q  <= 1'b0;
      pakm_q   <= '0;
      ssid_q   <= 1'b0;
      rsn_q    <= 1'b0;
      akm_q    <= '0;
    end else begin
      cnt_q    <= cnt_d;
      fc_q     <= fc_d;
      pad_q    <= pad_d;
      a1_q     <= a1_d;
      a2_q     <= a2_d;
      a3_q     <= a3_d;
      phase_q  <= phase_d;
      tag_id_q <= tag_id_d;
      rem_q    <= rem_d;
      bidx_q   <= bidx_d;
      pssid_q  <= pssid_d;
      pakm_q   <= pakm_d;
      ssid_q   <= ssid_d;
      rsn_q    <= rsn_d;
      akm_q    <= akm_d;
    end
  end

  // ---------------------------------------------------------------- summary
  // built from the state including the last byte itself
  always_comb begin
    info.fc   = fc_upd;
    info.pad  = pad_upd;
    info.len  = cnt_upd;
    info.a1   = a1_upd;
    info.a2   = a2_upd;
    info.a3   = a3_upd;
    info.ssid = ssid_upd;
    info.rsn  = rsn_upd;
    info.akm  = akm_upd;
  end

  wmhp_result_calc u_result_calc (
    .info_i (info),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                            out_q.akm, out_q.rsn, out_q.ssid,
                            out_q.bss, out_q.ap, out_q.sta,
                            out_q.prot, out_q.hdr_len, out_q.status};
  assign m_axis_tuser_o  = out_q.kind;

  // ---------------------------------------------------------------- checks
  // a body phase always has bytes still to come
  `WMHP_ASSERT_NEVER(a_body_rem_nonzero, phase_q == TAG_BODY && rem_q == '0, "tag body with no bytes left")
  // byte count saturates at the frame limit
  `WMHP_ASSERT(a_cnt_bounded, cnt_q <= CNT_W'(MAX_FRAME_BYTES), "byte count beyond frame limit")
  // the frame state is cleared after a last byte
  `WMHP_ASSERT(a_clear_after_last, advance && in_last_q |=> cnt_q == '0 && phase_q == TAG_ID, "frame state not cleared")
  // a new summary is only loaded from a last byte
  `WMHP_ASSERT(a_summary_from_last, $rose(out_valid_q) |-> $past(in_valid_q && in_last_q), "summary without last byte")
  // header length is reported for good frames only
  `WMHP_ASSERT(a_len_only_ok, !out_valid_q || out_q.hdr_len == '0 || out_q.status == ST_OK, "header length on bad frame")

endmodule

// ===== test/wifi_mac_header_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wifi_mac_header_parser_unit_tb
// frame bytes go in on the slave stream, one summary per frame is checked
// ----------------------------------------------------------------------------
// A byte-level model of the parser runs alongside the unit and works out the
// summary of every frame as its last byte is taken. Directed frames cover each
// frame type, header length and padding case, the address choices and the tag
// walk with its short and cut-off tags.
// Random frames follow, close to half of them beacons and probe responses with
// random tags, mixed with data, control, short and noise frames, under several
// patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module wifi_mac_header_parser_unit_tb;
  import wmhp_pkg::*;

  localparam int PHASE_BYTES  = 350;   // random bytes per idling phase
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int STALL_LIMIT  = 4000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 10;

  // byte-level model of the parser and the summaries still owed by the unit
  class mac_summary_board;
    result_t       summaries_due[$];
    int unsigned   errors;
    logic [13:0]   byte_cnt;
    logic [15:0]   fc;
    logic          pad;
    logic [47:0]   addr[3];
    tag_phase_e    phase;
    logic [7:0]    tag_id;
    logic [7:0]    tag_left;
    logic [7:0]    tag_idx;
    logic          name_nz;
    logic [7:0]    akm_cand;
    logic          ssid_seen;
    logic          rsn_seen;
    logic [7:0]    akm_seen;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_cnt  = '0;
      fc        = '0;
      pad       = 1'b0;
      addr[0]   = '0;
      addr[1]   = '0;
      addr[2]   = '0;
      phase     = TAG_ID;
      tag_id    = '0;
      tag_left  = '0;
      tag_idx   = '0;
      name_nz   = 1'b0;
      akm_cand  = '0;
      ssid_seen = 1'b0;
      rsn_seen  = 1'b0;
      akm_seen  = '0;
    endfunction

    function logic [5:0] hdr_bytes(logic [15:0] fc_w, logic pad_w);
      logic [5:0] len;
      case (kind_e'(fc_w[3:2]))
        KIND_MGMT: len = 6'(HDR_LEN_MGMT);
        KIND_CTRL: begin
          if (fc_w[7:4] == SUBTYPE_CTS || fc_w[7:4] == SUBTYPE_ACK) len = 6'(HDR_LEN_CTRL_ACK);
          else if (fc_w[7]) len = 6'(HDR_LEN_CTRL_RTS);
          else len = 6'(HDR_LEN_MIN);
        end
        KIND_DATA: begin
          len = (fc_w[9:8] == DS_BOTH) ? 6'(HDR_LEN_DATA4) : 6'(HDR_LEN_DATA3);
          if (fc_w[7]) len = len + 6'(HDR_LEN_QOS_EXTRA);
        end
        default: len = 6'(HDR_LEN_MIN);
      endcase
      if (pad_w && len[1:0] != 2'b00) len = {len[5:2] + 4'd1, 2'b00};
      return len;
    endfunction

    function logic beacon_like();
      return kind_e'(fc[3:2]) == KIND_MGMT &&
             (fc[7:4] == SUBTYPE_BEACON || fc[7:4] == SUBTYPE_PROBE_RESP);
    endfunction

    function void walk_tag(logic [7:0] b);
      case (phase)
        TAG_ID: begin
          tag_id = b;
          phase  = TAG_LEN;
        end
        TAG_LEN: begin
          tag_left = b;
          tag_idx  = '0;
          name_nz  = 1'b0;
          akm_cand = '0;
          phase    = (b == 8'd0) ? TAG_ID : TAG_BODY;
        end
        default: begin
          if (tag_idx == 8'd0 && b != 8'd0) name_nz = 1'b1;
          if (tag_idx == RSN_AKM_INDEX) akm_cand = b;
          tag_idx  = tag_idx + 8'd1;
          tag_left = tag_left - 8'd1;
          if (tag_left == 8'd0) begin
            if (tag_id == TAG_ID_SSID && name_nz) ssid_seen = 1'b1;
            if (tag_id == TAG_ID_RSN && tag_idx == RSN_BODY_LEN) begin
              rsn_seen = 1'b1;
              akm_seen = akm_cand;
            end
            phase = TAG_ID;
          end
        end
      endcase
    endfunction

    // one accepted byte; on the last byte the summary is queued
    function void take_byte(logic [7:0] b, logic last, logic pad_in);
      logic [13:0] idx;
      logic [5:0]  hl;
      kind_e       kind;
      result_t     r;
      int          slot;
      idx = byte_cnt;
      if (idx < MAX_FRAME_BYTES) begin
        if (idx == FC_LOW_POS) begin
          pad = pad_in;
          fc  = {8'h00, b};
        end else if (idx == FC_HIGH_POS) begin
          fc[15:8] = b;
        end else if (idx >= ADDR1_POS && idx < ADDR_END_POS) begin
          slot       = (idx - ADDR1_POS) / 6;
          addr[slot] = {addr[slot][39:0], b};
        end else if (beacon_like() && idx >= hdr_bytes(fc, pad) + FIXED_FIELDS_LEN) begin
          walk_tag(b);
        end
        byte_cnt = idx + 14'd1;
      end
      if (!last) return;

      kind   = kind_e'(fc[3:2]);
      hl     = hdr_bytes(fc, pad);
      r      = '0;
      r.kind = kind;
      r.prot = fc[14];
      if (byte_cnt < MIN_FRAME_LEN || byte_cnt < hl) r.status = ST_SHORT;
      else if (kind == KIND_CTRL) r.status = ST_CONTROL;
      else if (kind == KIND_RSVD) r.status = ST_RESERVED;
      else if (kind == KIND_DATA && fc[9:8] == DS_BOTH) r.status = ST_FOUR_ADDR;
      else r.status = ST_OK;

      if (r.status == ST_OK) begin
        r.hdr_len = hl;
        if (kind == KIND_MGMT) begin
          r.ap = addr[2];
          if (addr[0] != addr[2]) r.sta = addr[0];
          else if (addr[1] != addr[2]) r.sta = addr[1];
          else r.sta = ADDR_NONE;
          if (beacon_like()) begin
            r.ssid = ssid_seen;
            r.rsn  = rsn_seen;
            r.akm  = akm_seen;
          end
        end else begin
          case (fc[9:8])
            DS_NONE: begin
              r.ap  = addr[2];
              r.bss = addr[2];
              r.sta = ADDR_NONE;
            end
            DS_FROM: begin
              r.sta = addr[0];
              r.ap  = addr[1];
              r.bss = addr[1];
            end
            default: begin
              r.ap  = addr[0];
              r.bss = addr[0];
              r.sta = addr[1];
            end
          endcase
        end
      end
      summaries_due.push_back(r);
      clear_frame();
    endfunction

    function void compare(string field, logic [47:0] want_v, logic [47:0] got_v);
      if (want_v !== got_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_summary(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
      result_t want;
      if (summaries_due.size() == 0) begin
        $error("summary transaction with no frame outstanding");
        errors++;
        return;
      end
      want = summaries_due.pop_front();
      compare("status", want.status, d[2:0]);
      compare("frame_kind", want.kind, u);
      compare("header_length", want.hdr_len, d[8:3]);
      compare("protected_flag", want.prot, d[9]);
      compare("station_address", want.sta, d[57:10]);
      compare("ap_address", want.ap, d[105:58]);
      compare("bssid_address", want.bss, d[153:106]);
      compare("ssid_present", want.ssid, d[154]);
      compare("rsn_found", want.rsn, d[155]);
      compare("rsn_akm", want.akm, d[163:156]);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [BYTE_W-1:0]      s_axis_tdata_i;   // data_byte
  logic                   s_axis_tlast_i;   // last_byte
  logic                   s_axis_tuser_i;   // pad_to_four
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // status, header_length, protected_flag, station, ap, bssid, ssid_present,
  // rsn_found, rsn_akm, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;   // frame_kind

  mac_summary_board sb;
  logic [7:0]       frame_q[$];     // bytes of the frame being built
  int               src_idle_pct;
  int               sink_stall_pct;
  logic             hold_request;
  int               bytes_sent;
  int               quiet_cycles;

  wifi_mac_header_parser_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // frame building
  // ---------------------------------------------------------------------------
  function automatic void put_random(int n);
    repeat (n) frame_q.push_back(8'($urandom_range(255)));
  endfunction

  // addresses go out first byte most significant
  function automatic void put_mac(logic [47:0] a);
    for (int i = 5; i >= 0; i--) frame_q.push_back(a[i*8 +: 8]);
  endfunction

  // frame control, duration and the three address fields
  function automatic void put_header(logic [15:0] fc, logic [47:0] a1, logic [47:0] a2,
                                     logic [47:0] a3);
    frame_q.delete();
    frame_q.push_back(fc[7:0]);
    frame_q.push_back(fc[15:8]);
    put_random(2);
    put_mac(a1);
    put_mac(a2);
    put_mac(a3);
  endfunction

  // header then random bytes, or the header cut, to the given length
  function automatic void put_plain(logic [15:0] fc, logic [47:0] a1, logic [47:0] a2,
                                    logic [47:0] a3, int total);
    put_header(fc, a1, a2, a3);
    if (total > frame_q.size()) put_random(total - frame_q.size());
    while (frame_q.size() > total) void'(frame_q.pop_back());
  endfunction

  function automatic void put_tag(logic [7:0] id, int len, bit first_zero);
    frame_q.push_back(id);
    frame_q.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == 0) frame_q.push_back(first_zero ? 8'd0 : 8'($urandom_range(1, 255)));
      else frame_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void put_random_tag();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) put_tag(TAG_ID_SSID, $urandom_range(12), $urandom_range(3) == 0);
    else if (pick < 6)
      put_tag(TAG_ID_RSN, ($urandom_range(3) != 0) ? 20 : $urandom_range(16, 24),
              $urandom_range(1));
    else put_tag(8'($urandom_range(255)), $urandom_range(12), $urandom_range(1));
  endfunction

  // station selection needs equal addresses often enough
  function automatic void pick_addrs(output logic [47:0] a1, output logic [47:0] a2,
                                     output logic [47:0] a3);
    int pick;
    a1   = {16'($urandom), 32'($urandom)};
    a2   = {16'($urandom), 32'($urandom)};
    a3   = {16'($urandom), 32'($urandom)};
    pick = $urandom_range(9);
    if (pick < 3) a1 = a3;
    if (pick == 0) a2 = a3;
    if (pick == 3) a1 = ADDR_NONE;
    if (pick == 4) a2 = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // driving: inputs change on the falling edge, handshakes seen on the rising
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last, logic pad);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    s_axis_tlast_i  = last;
    s_axis_tuser_i  = pad;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.take_byte(b, last, pad);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // pad flag only counts on the first byte, the rest carry noise there
  task automatic send_frame(logic pad);
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1, (i == 0) ? pad : 1'($urandom_range(1)));
  endtask

  task automatic send_plain(logic [15:0] fc, logic pad, int total);
    logic [47:0] a1, a2, a3;
    pick_addrs(a1, a2, a3);
    put_plain(fc, a1, a2, a3, total);
    send_frame(pad);
  endtask

  // beacons and probe responses with random tags for close to half, plus other frames and noise
  task automatic send_random_frame();
    logic [15:0] fc;
    logic [47:0] a1, a2, a3;
    logic        pad;
    int          pick;
    int          start;
    pad  = $urandom_range(1);
    fc   = 16'($urandom);
    pick = $urandom_range(99);
    pick_addrs(a1, a2, a3);
    if (pick < 45) begin
      fc[3:2] = KIND_MGMT;
      fc[7:4] = $urandom_range(1) ? SUBTYPE_BEACON : SUBTYPE_PROBE_RESP;
      put_header(fc, a1, a2, a3);
      put_random(HDR_LEN_MGMT - ADDR_END_POS + FIXED_FIELDS_LEN);
      repeat ($urandom_range(5)) put_random_tag();
      // tag cut off by the end of the frame
      if ($urandom_range(3) == 0) begin
        start = frame_q.size();
        put_random_tag();
        repeat ($urandom_range(1, frame_q.size() - start - 1)) void'(frame_q.pop_back());
      end
    end else if (pick < 55) begin
      fc[3:2] = KIND_MGMT;
      put_plain(fc, a1, a2, a3, HDR_LEN_MGMT + $urandom_range(20));
    end else if (pick < 75) begin
      fc[3:2] = KIND_DATA;
      put_plain(fc, a1, a2, a3, sb.hdr_bytes(fc, pad) + $urandom_range(16));
    end else if (pick < 83) begin
      fc[3:2] = $urandom_range(1) ? KIND_CTRL : KIND_RSVD;
      put_plain(fc, a1, a2, a3, sb.hdr_bytes(fc, pad) + $urandom_range(8));
    end else if (pick < 93) begin
      put_plain(fc, a1, a2, a3, $urandom_range(1, sb.hdr_bytes(fc, pad) - 1));
    end else begin
      frame_q.delete();
      put_random($urandom_range(1, 40));
    end
    send_frame(pad);
  endtask

  task automatic run_directed();
    logic [47:0] a1, a2, a3;
    // single byte frames, extremes of the byte
    frame_q = {8'h00};
    send_frame(1'b0);
    frame_q = {8'hFF};
    send_frame(1'b1);
    // control frames: cut short, ack length with and without padding, rts, other
    send_plain(16'h0004, 1'b0, 2);
    send_plain(16'h00C4, 1'b0, 10);
    send_plain(16'h00D4, 1'b1, 10);
    send_plain(16'h00B4, 1'b1, 16);
    send_plain(16'h0014, 1'b1, 6);
    // reserved type, long enough and too short
    send_plain(16'h000C, 1'b0, 4);
    send_plain(16'h00FC, 1'b1, 3);
    // data frames: each distribution system case, protected, qos with padding
    send_plain(16'h0008, 1'b0, 28);
    send_plain(16'h4208, 1'b1, 24);
    send_plain(16'h0108, 1'b0, 40);
    send_plain(16'h0308, 1'b0, 30);
    send_plain(16'h0088, 1'b1, 28);
    send_plain(16'h0088, 1'b1, 27);
    // management: first address matches bssid, then all three the same
    pick_addrs(a1, a2, a3);
    put_plain(16'h00D0, a3, a2, a3, 24);
    send_frame(1'b0);
    frame_q.delete();
    repeat (30) frame_q.push_back(8'h00);
    send_frame(1'b0);
    frame_q.delete();
    repeat (40) frame_q.push_back(8'hFF);
    send_frame(1'b1);
    // beacon: named ssid, full rsn, vendor tag, rsn one byte short
    pick_addrs(a1, a2, a3);
    put_header(16'h0080, a1, a2, a3);
    put_random(HDR_LEN_MGMT - ADDR_END_POS + FIXED_FIELDS_LEN);
    put_tag(TAG_ID_SSID, 5, 1'b0);
    put_tag(TAG_ID_RSN, 20, 1'b0);
    put_tag(8'd221, 3, 1'b1);
    put_tag(TAG_ID_RSN, 19, 1'b0);
    send_frame(1'b1);
    // probe response: hidden ssid, long rsn, full rsn, empty ssid, cut rsn
    pick_addrs(a1, a2, a3);
    put_header(16'h4050, a1, a2, a3);
    put_random(HDR_LEN_MGMT - ADDR_END_POS + FIXED_FIELDS_LEN);
    put_tag(TAG_ID_SSID, 4, 1'b1);
    put_tag(TAG_ID_RSN, 21, 1'b0);
    put_tag(TAG_ID_RSN, 20, 1'b1);
    put_tag(TAG_ID_SSID, 0, 1'b0);
    put_tag(TAG_ID_RSN, 20, 1'b0);
    repeat (3) void'(frame_q.pop_back());
    send_frame(1'b0);
    // beacon with no tags, and one a byte short of its header
    send_plain(16'h0080, 1'b0, 36);
    send_plain(16'h0080, 1'b1, 23);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    bit hold_done;
    hold_done       = 1'b0;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready_i = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // every summary transaction goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_summary(m_axis_tdata_o, m_axis_tuser_o);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_end;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    s_axis_tuser_i  = 1'b0;
    rst_ni          = 1'b0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    hold_request    = 1'b0;
    bytes_sent      = 0;
    quiet_cycles    = 0;
    sb              = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();

    // idling phases: none, sender gaps, receiver stalls, a little of both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          hold_request   = 1'b1;   // fill the unit while the sender keeps going
        end
        1: begin
          src_idle_pct   = 68;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 68;
        end
        default: begin
          src_idle_pct   = 7;
          sink_stall_pct = 7;
        end
      endcase
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_random_frame();
    end
    s_axis_tvalid_i = 1'b0;

    while (sb.summaries_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
